// ===== sv/rxhc_pkg.sv =====
package rxhc_pkg;

  // ring geometry, a power of two from 1024 to 65536 bytes
  localparam int unsigned RING_BYTES = 65536;
  localparam int unsigned RING_AW    = $clog2(RING_BYTES);

  // fixed field widths
  localparam int unsigned STATUS_W   = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned PTR_W      = 16;
  localparam int unsigned CHUNK_W    = 13;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned VERDICT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 13;

  // compare width for chunk split: covers a full ring and a 13-bit length
  localparam int unsigned CMP_W      = 17;

  // header and dword constants
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned CRC_BYTES  = 4;
  localparam int unsigned RP_BIAS    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DELIVER_ENABLE = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] MAX_FRAME_LEN_RST = CFG_DATA_W'(1514);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_GOOD       = 2'd0,
    VERDICT_BAD_LEN    = 2'd1,
    VERDICT_BAD_STATUS = 2'd2,
    VERDICT_DROPPED    = 2'd3
  } verdict_e;

  typedef struct packed {
    verdict_e             verdict;
    logic [PTR_W-1:0]     payload_start;
    logic [CHUNK_W-1:0]   payload_length;
    logic [CHUNK_W-1:0]   first_chunk_len;
    logic [CHUNK_W-1:0]   second_chunk_len;
    logic [PTR_W-1:0]     read_pointer_value;
    logic [CNT_W-1:0]     good_count;
    logic [CNT_W-1:0]     error_count;
    logic [CNT_W-1:0]     drop_count;
  } result_t;

endpackage

// ===== sv/rxhc_if.sv =====
interface rxhc_hdr_if;
  import rxhc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] header_status;
  logic [LEN_W-1:0]    header_length;

  modport source (output valid, header_status, header_length, input ready);
  modport sink   (input valid, header_status, header_length, output ready);
endinterface

interface rxhc_res_if;
  import rxhc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [PTR_W-1:0]     payload_start;
  logic [CHUNK_W-1:0]   payload_length;
  logic [CHUNK_W-1:0]   first_chunk_len;
  logic [CHUNK_W-1:0]   second_chunk_len;
  logic [PTR_W-1:0]     read_pointer_value;
  logic [CNT_W-1:0]     good_count;
  logic [CNT_W-1:0]     error_count;
  logic [CNT_W-1:0]     drop_count;

  modport source (
    output valid, verdict, payload_start, payload_length, first_chunk_len,
           second_chunk_len, read_pointer_value, good_count, error_count,
           drop_count,
    input  ready
  );
  modport sink (
    input  valid, verdict, payload_start, payload_length, first_chunk_len,
           second_chunk_len, read_pointer_value, good_count, error_count,
           drop_count,
    output ready
  );
endinterface

interface rxhc_cfg_if;
  import rxhc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rx_ring_header_consumer.sv =====
// channel  | dir | payload                                  | accepted when
// ---------+-----+------------------------------------------+-------------------
// hdr_i    | in  | header_status, header_length             | valid && ready
// res_o    | out | verdict, start, lengths, rd ptr, counts  | valid && ready
// cfg_i    | in  | index, data (max_frame_len, deliver_en)  | valid (ready = 1)
//
// one header word per cycle sustained while res_o does not stall; a word
// goes from the input register via classify/advance into the result register
// the offset add-and-align and the chunk split sit between the two registers
// reset clears offset, counters, valid flags and restores register defaults
// a stall on res_o holds the result; hdr_i still takes one word into the
// input register, so the block fills up before it pushes back
module rx_ring_header_consumer (
  input  logic             clk_i,
  input  logic             rst_ni,
  rxhc_hdr_if.sink         hdr_i,
  rxhc_res_if.source       res_o,
  rxhc_cfg_if.sink         cfg_i
);
  import rxhc_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] max_len_q;
  logic                  deliver_q;

  // input register stage
  logic                  s1_valid_q;
  logic [STATUS_W-1:0]   s1_status_q;
  logic [LEN_W-1:0]      s1_len_q;

  // architectural state
  logic [RING_AW-1:0]    offset_q, offset_d;
  logic [CNT_W-1:0]      good_q, good_d;
  logic [CNT_W-1:0]      err_q, err_d;
  logic [CNT_W-1:0]      drop_q, drop_d;

  // result register stage
  logic                  out_valid_q;
  result_t               res_q, res_d;

  logic                  out_adv;
  logic                  in_acc;
  logic                  s2_load;

  // classify / advance signals
  logic [RING_AW-1:0]    start;
  logic [LEN_W:0]        len_lim;
  logic                  bad_len;
  logic [LEN_W:0]        advance;
  logic [LEN_W+1:0]      next_sum;
  logic [RING_AW-1:0]    new_off;
  logic [RING_AW-1:0]    rp_off;
  logic [LEN_W-1:0]      plen;
  logic [CMP_W-1:0]      room;
  logic [CHUNK_W-1:0]    first_len;
  verdict_e              verdict;

  // ---------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------
  assign out_adv     = !out_valid_q || res_o.ready;
  assign hdr_i.ready = !s1_valid_q || out_adv;
  assign in_acc      = hdr_i.valid && hdr_i.ready;
  assign s2_load     = s1_valid_q && out_adv;
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------------
  // config writes; unknown indexes are dropped
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_FRAME_LEN_RST;
      deliver_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_MAX_FRAME_LEN) begin
        max_len_q <= cfg_i.data;
      end else if (cfg_i.index == REG_DELIVER_ENABLE) begin
        deliver_q <= cfg_i.data[0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (out_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_status_q <= hdr_i.header_status;
      s1_len_q    <= hdr_i.header_length;
    end
  end

  // ---------------------------------------------------------------------
  // classify and advance
  // ---------------------------------------------------------------------
  always_comb begin
    // payload sits right after the 4-byte header, wrapped at ring end
    start   = offset_q + RING_AW'(HDR_BYTES);
    len_lim = (LEN_W+1)'(max_len_q) + (LEN_W+1)'(CRC_BYTES);
    bad_len = (s1_len_q < LEN_W'(CRC_BYTES)) || ({1'b0, s1_len_q} > len_lim);
    plen    = s1_len_q - LEN_W'(CRC_BYTES);

    priority if (bad_len) begin
      verdict = VERDICT_BAD_LEN;
    end else if (!s1_status_q[0]) begin
      verdict = VERDICT_BAD_STATUS;
    end else if (plen == '0) begin
      verdict = VERDICT_DROPPED;
    end else begin
      verdict = VERDICT_GOOD;
    end

    // bad length skips only the header, everything else skips the frame too
    advance  = bad_len ? (LEN_W+1)'(HDR_BYTES)
                       : ({1'b0, s1_len_q} + (LEN_W+1)'(HDR_BYTES));
    next_sum = (LEN_W+2)'(offset_q) + (LEN_W+2)'(advance) + (LEN_W+2)'(3);
    new_off  = {next_sum[RING_AW-1:2], 2'b00};
    // pointer value wraps at the ring size
    rp_off   = new_off - RING_AW'(RP_BIAS);

    // split at ring end; when good, plen never exceeds max_frame_len
    room      = CMP_W'(RING_BYTES) - CMP_W'(start);
    first_len = (CMP_W'(plen[CHUNK_W-1:0]) < room) ? plen[CHUNK_W-1:0]
                                                   : room[CHUNK_W-1:0];

    offset_d = offset_q;
    good_d   = good_q;
    err_d    = err_q;
    drop_d   = drop_q;
    if (s2_load) begin
      offset_d = new_off;
      unique case (verdict)
        VERDICT_GOOD:       good_d = good_q + CNT_W'(1);
        VERDICT_BAD_LEN,
        VERDICT_BAD_STATUS: err_d  = err_q + CNT_W'(1);
        VERDICT_DROPPED:    drop_d = drop_q + CNT_W'(1);
        default:            ;
      endcase
    end

    res_d                    = '0;
    res_d.verdict            = verdict;
    res_d.payload_start      = PTR_W'(start);
    res_d.read_pointer_value = PTR_W'(rp_off);
    res_d.good_count         = good_d;
    res_d.error_count        = err_d;
    res_d.drop_count         = drop_d;
    if (verdict == VERDICT_GOOD) begin
      res_d.payload_length = plen[CHUNK_W-1:0];
      if (deliver_q) begin
        res_d.first_chunk_len  = first_len;
        res_d.second_chunk_len = plen[CHUNK_W-1:0] - first_len;
      end
    end
  end

  // ---------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      good_q      <= '0;
      err_q       <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      offset_q <= offset_d;
      good_q   <= good_d;
      err_q    <= err_d;
      drop_q   <= drop_d;
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.verdict            = res_q.verdict;
  assign res_o.payload_start      = res_q.payload_start;
  assign res_o.payload_length     = res_q.payload_length;
  assign res_o.first_chunk_len    = res_q.first_chunk_len;
  assign res_o.second_chunk_len   = res_q.second_chunk_len;
  assign res_o.read_pointer_value = res_q.read_pointer_value;
  assign res_o.good_count         = res_q.good_count;
  assign res_o.error_count        = res_q.error_count;
  assign res_o.drop_count         = res_q.drop_count;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q[1:0] == 2'b00)
    else $error("read offset lost dword alignment");

  a_one_count_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> (good_q + err_q + drop_q) ==
                ($past(good_q + err_q + drop_q) + CNT_W'(1)))
    else $error("counters did not advance by exactly one");

  a_idle_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_load |=> $stable(offset_q) && $stable(good_q) && $stable(err_q)
                 && $stable(drop_q))
    else $error("state changed without a word");

  a_chunks_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.first_chunk_len != '0) |->
      (res_q.first_chunk_len + res_q.second_chunk_len) == res_q.payload_length)
    else $error("chunk split does not add up to payload length");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q)
    else $error("input register dropped a word while stalled");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rxhc_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PHASE_WORDS   = 255;
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned LIMIT_NS      = 5_000_000;
  localparam int unsigned NUM_ROWS      = 26;
  // random seeks only with frames long enough to cross the ring in a few words
  localparam int unsigned SEEK_MIN_FRAME = 1024;

  // an index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);

  typedef enum logic [1:0] {ROW_HEADER, ROW_WRITE, ROW_SEEK} row_kind_e;

  // header rows: arg_a status, arg_b length; write rows: arg_a index, arg_b data;
  // seek rows: arg_a target ring offset
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
    logic        typed;
    verdict_e    verdict;
  } stim_row_t;

  stim_row_t plan [NUM_ROWS] = '{
    '{ROW_HEADER, 16'h0001, 16'd64,   1'b1, VERDICT_GOOD},
    '{ROW_HEADER, 16'hFFFF, 16'd0,    1'b1, VERDICT_BAD_LEN},
    '{ROW_HEADER, 16'h0001, 16'd3,    1'b1, VERDICT_BAD_LEN},
    '{ROW_HEADER, 16'h0001, 16'd4,    1'b1, VERDICT_DROPPED},
    '{ROW_HEADER, 16'h0000, 16'd100,  1'b1, VERDICT_BAD_STATUS},
    '{ROW_HEADER, 16'hFFFE, 16'd1518, 1'b1, VERDICT_BAD_STATUS},
    '{ROW_HEADER, 16'h0001, 16'd1518, 1'b1, VERDICT_GOOD},
    '{ROW_HEADER, 16'hFFFF, 16'd1519, 1'b1, VERDICT_BAD_LEN},
    '{ROW_HEADER, 16'hFFFF, 16'hFFFF, 1'b1, VERDICT_BAD_LEN},
    '{ROW_WRITE,  16'(REG_DELIVER_ENABLE), 16'd1,    1'b0, VERDICT_GOOD},
    '{ROW_WRITE,  16'(REG_MAX_FRAME_LEN),  16'h1FFF, 1'b0, VERDICT_GOOD},
    '{ROW_HEADER, 16'h8001, 16'd8195, 1'b1, VERDICT_GOOD},
    '{ROW_HEADER, 16'h0001, 16'd8196, 1'b1, VERDICT_BAD_LEN},
    // park the offset one dword before the ring end, next payload starts at 0
    '{ROW_SEEK,   16'(RING_BYTES - HDR_BYTES), 16'd0, 1'b0, VERDICT_GOOD},
    '{ROW_HEADER, 16'hAAAB, 16'd104,  1'b0, VERDICT_GOOD},
    '{ROW_WRITE,  16'(REG_MAX_FRAME_LEN),  16'd0,    1'b0, VERDICT_GOOD},
    '{ROW_HEADER, 16'h0001, 16'd4,    1'b1, VERDICT_DROPPED},
    '{ROW_HEADER, 16'h0001, 16'd5,    1'b1, VERDICT_BAD_LEN},
    '{ROW_HEADER, 16'h0000, 16'd4,    1'b1, VERDICT_BAD_STATUS},
    '{ROW_WRITE,  16'(REG_SPARE),          16'h1FFF, 1'b0, VERDICT_GOOD},
    '{ROW_HEADER, 16'h0001, 16'd5,    1'b1, VERDICT_BAD_LEN},
    '{ROW_WRITE,  16'(REG_MAX_FRAME_LEN),  16'd60,   1'b0, VERDICT_GOOD},
    '{ROW_HEADER, 16'h0001, 16'd64,   1'b1, VERDICT_GOOD},
    '{ROW_HEADER, 16'h0001, 16'd65,   1'b1, VERDICT_BAD_LEN},
    '{ROW_WRITE,  16'(REG_DELIVER_ENABLE), 16'd0,    1'b0, VERDICT_GOOD},
    '{ROW_HEADER, 16'h0001, 16'd5,    1'b1, VERDICT_GOOD}
  };

  // per random phase: frame limit (last one drawn at run time) and delivery
  logic [CFG_DATA_W-1:0] phase_max [NUM_PHASES] =
    '{13'd1514, 13'd4096, 13'd60, 13'd8191, 13'd0, 13'd1514};
  logic phase_deliver [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni;

  rxhc_hdr_if hdr ();
  rxhc_res_if res ();
  rxhc_cfg_if cfg ();

  rx_ring_header_consumer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (hdr),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always #5 clk_i = ~clk_i;

  // ring state as the block should hold it
  logic [PTR_W-1:0]      ring_offset;
  logic [CNT_W-1:0]      good_total;
  logic [CNT_W-1:0]      error_total;
  logic [CNT_W-1:0]      drop_total;
  logic [CFG_DATA_W-1:0] max_frame;
  logic                  deliver_on;

  result_t     expected_results [$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned writes_done = 0;
  int unsigned split_payloads = 0;
  int unsigned ring_start_payloads = 0;
  int unsigned verdict_seen [4] = '{0, 0, 0, 0};
  int unsigned sender_idle_pct;
  int unsigned reader_idle_pct;
  logic        hold_request;

  // classify one header, advance the ring and counters, return the result word
  function automatic result_t classify_header(input logic [STATUS_W-1:0] status,
                                              input logic [LEN_W-1:0] length);
    result_t     r;
    int unsigned off, start, adv, plen, first, nxt;
    r     = '0;
    off   = ring_offset;
    start = (off + HDR_BYTES) % RING_BYTES;
    if (length < CRC_BYTES || length > max_frame + CRC_BYTES) begin
      // bad length skips only the header itself
      r.verdict = VERDICT_BAD_LEN;
      error_total++;
      adv = HDR_BYTES;
    end else if (!status[0]) begin
      r.verdict = VERDICT_BAD_STATUS;
      error_total++;
      adv = length + HDR_BYTES;
    end else begin
      plen = length - CRC_BYTES;
      if (plen > 0 && plen <= max_frame) begin
        r.verdict        = VERDICT_GOOD;
        r.payload_length = CHUNK_W'(plen);
        good_total++;
        if (deliver_on) begin
          // split where the payload runs past the ring end
          first = (plen < RING_BYTES - start) ? plen : RING_BYTES - start;
          r.first_chunk_len  = CHUNK_W'(first);
          r.second_chunk_len = CHUNK_W'(plen - first);
        end
      end else begin
        r.verdict = VERDICT_DROPPED;
        drop_total++;
      end
      adv = length + HDR_BYTES;
    end
    nxt         = ((off + adv + 3) & ~32'd3) % RING_BYTES;
    ring_offset = PTR_W'(nxt);
    r.payload_start      = PTR_W'(start);
    r.read_pointer_value = PTR_W'((nxt - RP_BIAS) & (RING_BYTES - 1));
    r.good_count         = good_total;
    r.error_count        = error_total;
    r.drop_count         = drop_total;
    verdict_seen[r.verdict]++;
    if (r.second_chunk_len != 0) split_payloads++;
    if (r.verdict == VERDICT_GOOD && start == 0) ring_start_payloads++;
    return r;
  endfunction

  task automatic send_header(input logic [STATUS_W-1:0] status,
                             input logic [LEN_W-1:0] length,
                             input logic typed, input verdict_e verdict);
    result_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      hdr.valid <= 1'b0;
      @(posedge clk_i);
    end
    hdr.valid         <= 1'b1;
    hdr.header_status <= status;
    hdr.header_length <= length;
    do @(posedge clk_i); while (!hdr.ready);
    want = classify_header(status, length);
    if (typed) want.verdict = verdict;
    expected_results.push_back(want);
    words_sent++;
  endtask

  // stop sending and wait until every result word is back
  task automatic settle();
    hdr.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (index == REG_MAX_FRAME_LEN) max_frame = data;
    else if (index == REG_DELIVER_ENABLE) deliver_on = data[0];
    writes_done++;
  endtask

  // walk the read offset onto a dword target with frames of valid length, or a bad-length header for the last dword
  task automatic seek_ring_offset(input int unsigned target);
    int unsigned gap;
    while (ring_offset != target) begin
      gap = (target + RING_BYTES - ring_offset) % RING_BYTES;
      if (gap == HDR_BYTES)
        send_header(16'($urandom), '0, 1'b0, VERDICT_GOOD);
      else if (gap - HDR_BYTES <= max_frame + CRC_BYTES)
        send_header(16'($urandom) | 16'h1, LEN_W'(gap - HDR_BYTES), 1'b0, VERDICT_GOOD);
      else
        send_header(16'($urandom) | 16'h1, LEN_W'(max_frame + CRC_BYTES), 1'b0,
                    VERDICT_GOOD);
    end
  endtask

  task automatic send_random_header();
    int unsigned        pick, top;
    logic [STATUS_W-1:0] status;
    pick   = $urandom_range(99);
    status = 16'($urandom);
    top    = max_frame + CRC_BYTES;
    if (pick < 3 && max_frame >= SEEK_MIN_FRAME) begin
      // land near the ring end, then a good frame that starts at it or may wrap it
      seek_ring_offset($urandom_range(1) ? RING_BYTES - HDR_BYTES :
                       RING_BYTES - HDR_BYTES * $urandom_range(2, RING_BYTES / 64));
      send_header(status | 16'h1, LEN_W'($urandom_range(CRC_BYTES + 1, top)), 1'b0,
                  VERDICT_GOOD);
    end else if (pick < 70)
      send_header(status | 16'h1, LEN_W'($urandom_range(CRC_BYTES + 1, top)), 1'b0,
                  VERDICT_GOOD);
    else if (pick < 78)
      send_header(status | 16'h1, LEN_W'(CRC_BYTES), 1'b0, VERDICT_GOOD);
    else if (pick < 86)
      send_header(status & 16'hFFFE, LEN_W'($urandom_range(CRC_BYTES, top)), 1'b0,
                  VERDICT_GOOD);
    else if (pick < 93)
      send_header(status, $urandom_range(1) ? LEN_W'($urandom_range(0, CRC_BYTES - 1)) :
                  LEN_W'($urandom_range(top + 1, 16'hFFFF)), 1'b0, VERDICT_GOOD);
    else
      send_header(status, 16'($urandom), 1'b0, VERDICT_GOOD);
  endtask

  function automatic void check_field(input string field, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    end
  endfunction

  // result side: compare every accepted word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result word with nothing outstanding, verdict %0d", $time,
                   res.verdict);
      end else begin
        want = expected_results.pop_front();
        check_field("verdict", want.verdict, res.verdict);
        check_field("payload_start", want.payload_start, res.payload_start);
        check_field("payload_length", want.payload_length, res.payload_length);
        check_field("first_chunk_len", want.first_chunk_len, res.first_chunk_len);
        check_field("second_chunk_len", want.second_chunk_len, res.second_chunk_len);
        check_field("read_pointer_value", want.read_pointer_value, res.read_pointer_value);
        check_field("good_count", want.good_count, res.good_count);
        check_field("error_count", want.error_count, res.error_count);
        check_field("drop_count", want.drop_count, res.drop_count);
      end
    end
  end

  // result ready: random stalls, plus one long hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request <= 1'b0;
        res.ready    <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      res.ready <= ($urandom_range(99) >= reader_idle_pct);
    end
  end

  initial begin
    int unsigned phase_end;
    rst_ni            = 1'b0;
    hdr.valid         = 1'b0;
    hdr.header_status = '0;
    hdr.header_length = '0;
    cfg.valid         = 1'b0;
    cfg.index         = '0;
    cfg.data          = '0;
    hold_request      = 1'b0;
    sender_idle_pct   = 34;
    reader_idle_pct   = 88;
    ring_offset       = '0;
    good_total        = '0;
    error_total       = '0;
    drop_total        = '0;
    max_frame         = MAX_FRAME_LEN_RST;
    deliver_on        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_HEADER: send_header(plan[i].arg_a, plan[i].arg_b, plan[i].typed, plan[i].verdict);
        ROW_WRITE:  write_reg(CFG_IDX_W'(plan[i].arg_a), CFG_DATA_W'(plan[i].arg_b));
        default:    seek_ring_offset(plan[i].arg_a);
      endcase
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          sender_idle_pct = 34;
          reader_idle_pct = 88;
        end
        1: begin
          sender_idle_pct = 88;
          reader_idle_pct = 34;
        end
        default: begin
          sender_idle_pct = 0;
          reader_idle_pct = 0;
        end
      endcase
      write_reg(REG_MAX_FRAME_LEN, (p == NUM_PHASES - 1) ?
                CFG_DATA_W'($urandom_range(60, 4096)) : phase_max[p]);
      write_reg(REG_DELIVER_ENABLE, CFG_DATA_W'(phase_deliver[p]));
      // last phase: long result stall while headers keep coming
      if (p == NUM_PHASES - 1) hold_request <= 1'b1;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) send_random_header();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d header words: %0d good, %0d bad length, %0d bad status, %0d empty",
             words_sent, verdict_seen[VERDICT_GOOD], verdict_seen[VERDICT_BAD_LEN],
             verdict_seen[VERDICT_BAD_STATUS], verdict_seen[VERDICT_DROPPED]);
    $display("%0d register writes, %0d payloads split at ring end, %0d at ring start, %0d errors",
             writes_done, split_payloads, ring_start_payloads, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rxhc_pkg.sv
sv/rxhc_if.sv
sv/rx_ring_header_consumer.sv
tb/sv/testbench.sv
